FILE: sv/knnbl_pkg.sv
// ----------------------------------------------------------------------------
// knnbl_pkg
// Shared types and constants of the nearest-neighbor list update unit.
// ----------------------------------------------------------------------------
package knnbl_pkg;

    localparam int ID_W    = 10;
    localparam int DIST_W  = 32;
    localparam int POINT_W = 10;
    localparam int SLOT_W  = 4;
    localparam int KCFG_W  = 5;

    // input tdata layout
    localparam int S_TDATA_W   = 64;
    localparam int S_POINT_LSB = 0;
    localparam int S_CAND_LSB  = 10;
    localparam int S_DIST_LSB  = 20;
    localparam int S_MARK_BIT  = 52;
    localparam int S_SLOT_LSB  = 53;

    // output tdata layout
    localparam int M_TDATA_W = 48;
    localparam int M_PAD_W   = 3;

    localparam logic FUNC_UPDATE = 1'b0;
    localparam logic FUNC_READ   = 1'b1;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [DIST_W-1:0] distance;
        logic              mark;
    } entry_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD,
        ST_SEARCH,
        ST_DONE
    } state_t;

endpackage

FILE: sv/knnbl_ram.sv
// ----------------------------------------------------------------------------
// knnbl_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module knnbl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_array [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_array[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem_array[raddr];
        end
    end

endmodule

FILE: sv/knnbl_max_tree.sv
// ----------------------------------------------------------------------------
// knnbl_max_tree
// Registered pairwise maximum tree over one row of distances; the lower
// slot wins on ties. One register stage per tree level, after a registered leaf stage.
// ----------------------------------------------------------------------------
module knnbl_max_tree
    import knnbl_pkg::*;
#(
    parameter int NEIGHBORS = 16
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  logic                                        in_valid,
    input  logic [NEIGHBORS-1:0][DIST_W-1:0]            in_dist,
    output logic                                        out_valid,
    output logic [DIST_W-1:0]                           out_dist,
    output logic [(NEIGHBORS > 1 ? $clog2(NEIGHBORS) : 1)-1:0] out_idx
);

    localparam int LEVELS = $clog2(NEIGHBORS);
    localparam int NP     = 1 << LEVELS;
    localparam int IDX_W  = (NEIGHBORS > 1) ? LEVELS : 1;

    logic [DIST_W-1:0] dist_reg  [LEVELS+1][NP];
    logic [IDX_W-1:0]  idx_reg   [LEVELS+1][NP];
    logic              valid_reg [LEVELS+1];

    // leaf stage
    for (genvar j = 0; j < NP; j++) begin : g_leaf
        if (j < NEIGHBORS) begin : g_used
            always_ff @(posedge aclk) begin
                dist_reg[0][j] <= in_dist[j];
            end
        end else begin : g_pad
            always_ff @(posedge aclk) begin
                dist_reg[0][j] <= '0;
            end
        end
        always_ff @(posedge aclk) begin
            idx_reg[0][j] <= IDX_W'(j);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg[0] <= 1'b0;
        end else begin
            valid_reg[0] <= in_valid;
        end
    end

    for (genvar l = 1; l <= LEVELS; l++) begin : g_level
        for (genvar i = 0; i < (NP >> l); i++) begin : g_node
            always_ff @(posedge aclk) begin
                if (dist_reg[l-1][2*i+1] > dist_reg[l-1][2*i]) begin
                    dist_reg[l][i] <= dist_reg[l-1][2*i+1];
                    idx_reg[l][i]  <= idx_reg[l-1][2*i+1];
                end else begin
                    dist_reg[l][i] <= dist_reg[l-1][2*i];
                    idx_reg[l][i]  <= idx_reg[l-1][2*i];
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[l] <= 1'b0;
            end else begin
                valid_reg[l] <= valid_reg[l-1];
            end
        end
    end

    assign out_valid = valid_reg[LEVELS];
    assign out_dist  = dist_reg[LEVELS][0];
    assign out_idx   = idx_reg[LEVELS][0];

endmodule

FILE: sv/knn_best_list_update_unit.sv
// ----------------------------------------------------------------------------
// knn_best_list_update_unit
// Per-point nearest-neighbor lists held as one memory row per point.
//
//   channel   dir   handshake           contents
//   s_        in    s_tvalid/s_tready   tdata: point, candidate, distance,
//                                       new_flag, slot; tuser: func
//   m_        out   m_tvalid/m_tready   tdata: updated, slot_valid,
//                                       neighbor_index, distance, new
//   cfg_      in    cfg_we              neighbors in use
//
// A read, a rejected duplicate, a point out of range or an update of a list
// that is still filling goes from the row read in ST_LOAD straight to ST_DONE;
// any other update of a full list passes through ST_SEARCH first, waiting for
// the registered maximum tree over the row.
// One row read per transaction and one row write-back when the list changes,
// one transaction at a time.
// After reset a clearing pass writes all POINTS rows, one per cycle, with
// s_tready low; configuration writes are taken during it.
// A waiting result in the output register does not block acceptance; a new
// result waits in ST_DONE until the output register frees up.
// ----------------------------------------------------------------------------
module knn_best_list_update_unit
    import knnbl_pkg::*;
#(
    parameter int POINTS    = 1024,
    parameter int NEIGHBORS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [KCFG_W-1:0]    cfg_wdata,   // neighbors_in_use
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,     // point, candidate, distance,
                                              // new_flag, slot, zero pad
    input  logic                 s_tuser,     // func
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata      // updated, slot_valid,
                                              // neighbor_index,
                                              // neighbor_distance,
                                              // neighbor_new, zero pad
);

    localparam int AW      = $clog2(POINTS);
    localparam int FILL_W  = $clog2(NEIGHBORS + 1);
    localparam int IDX_W   = (NEIGHBORS > 1) ? $clog2(NEIGHBORS) : 1;
    localparam int ENTRY_W = $bits(entry_t);
    localparam int ROW_W   = NEIGHBORS * ENTRY_W;
    localparam int RAM_W   = FILL_W + ROW_W;
    localparam int K_RESET = (16 > NEIGHBORS) ? NEIGHBORS : 16;

    state_t state_reg, state_next;

    logic [FILL_W-1:0] k_reg, k_next;
    logic [AW-1:0]     clr_addr_reg;

    logic              func_reg;
    logic              point_ok_reg;
    logic [AW-1:0]     addr_reg;
    logic [ID_W-1:0]   cand_reg;
    logic [DIST_W-1:0] dist_reg;
    logic              mark_reg;
    logic [SLOT_W-1:0] slot_reg;

    entry_t [NEIGHBORS-1:0] row_reg;
    logic [FILL_W-1:0]      fill_reg;
    logic                   full_reg;
    logic                   dup_reg;
    logic                   rd_valid_reg;
    entry_t                 rd_entry_reg;
    logic [DIST_W-1:0]      far_reg;
    logic [IDX_W-1:0]       at_reg;

    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    // incoming fields
    logic [POINT_W-1:0] in_point;
    logic               in_point_ok;
    logic [AW-1:0]      in_addr;
    logic               accept;

    // memory port
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [RAM_W-1:0] ram_wdata;
    logic             ram_re;
    logic [RAM_W-1:0] ram_rdata;

    entry_t [NEIGHBORS-1:0] rd_entries;
    logic [FILL_W-1:0]      rd_fill;
    logic                   full_now;
    logic                   dup_now;
    logic [FILL_W-1:0]      dup_lim;
    logic                   rd_valid_now;
    entry_t                 rd_entry_now;
    logic                   search_go;

    logic [NEIGHBORS-1:0][DIST_W-1:0] leaf_dist;
    logic                             tree_out_valid;
    logic [DIST_W-1:0]                tree_out_dist;
    logic [IDX_W-1:0]                 tree_out_idx;

    logic                   out_free;
    logic                   out_load;
    logic                   upd;
    entry_t                 new_entry;
    entry_t [NEIGHBORS-1:0] wr_entries;
    logic [FILL_W-1:0]      wr_fill;
    logic [M_TDATA_W-1:0]   result;

    assign in_point    = s_tdata[S_POINT_LSB +: POINT_W];
    assign in_point_ok = (32'(in_point) < 32'(POINTS));
    assign in_addr     = AW'(32'(in_point));
    assign accept      = s_tvalid && s_tready;

    // configuration, clamped to 1..NEIGHBORS when written
    always_comb begin
        if (cfg_wdata == '0) begin
            k_next = FILL_W'(1);
        end else if (32'(cfg_wdata) > 32'(NEIGHBORS)) begin
            k_next = FILL_W'(NEIGHBORS);
        end else begin
            k_next = FILL_W'(cfg_wdata);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg <= FILL_W'(K_RESET);
        end else if (cfg_we) begin
            k_reg <= k_next;
        end
    end

    knnbl_ram #(
        .WIDTH (RAM_W),
        .DEPTH (POINTS)
    ) u_row_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (in_addr),
        .rdata (ram_rdata)
    );

    // row unpacking and first look at the row
    assign rd_entries = ram_rdata[ROW_W-1:0];
    assign rd_fill    = ram_rdata[RAM_W-1 -: FILL_W];
    assign full_now   = (rd_fill >= k_reg);
    assign dup_lim    = full_now ? k_reg : rd_fill;

    always_comb begin
        dup_now      = 1'b0;
        rd_entry_now = '0;
        for (int j = 0; j < NEIGHBORS; j++) begin
            if (rd_entries[j].id == cand_reg && j < int'(dup_lim)) begin
                dup_now = 1'b1;
            end
            if (j == int'(slot_reg)) begin
                rd_entry_now = rd_entries[j];
            end
            leaf_dist[j] = (j < int'(k_reg)) ? rd_entries[j].distance : '0;
        end
    end

    assign rd_valid_now = point_ok_reg && (int'(slot_reg) < int'(rd_fill))
                          && (int'(slot_reg) < int'(k_reg));
    assign search_go    = (func_reg == FUNC_UPDATE) && point_ok_reg && full_now
                          && !dup_now;

    knnbl_max_tree #(
        .NEIGHBORS (NEIGHBORS)
    ) u_max_tree (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  ((state_reg == ST_LOAD) && search_go),
        .in_dist   (leaf_dist),
        .out_valid (tree_out_valid),
        .out_dist  (tree_out_dist),
        .out_idx   (tree_out_idx)
    );

    // decision and write-back row
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        upd = 1'b0;
        if (func_reg == FUNC_UPDATE && point_ok_reg && !dup_reg) begin
            if (!full_reg) begin
                upd = 1'b1;
            end else if (dist_reg < far_reg) begin
                upd = 1'b1;
            end
        end
    end

    assign new_entry = '{id: cand_reg, distance: dist_reg, mark: mark_reg};
    assign wr_fill   = full_reg ? fill_reg : fill_reg + FILL_W'(1);

    always_comb begin
        for (int j = 0; j < NEIGHBORS; j++) begin
            if (full_reg ? (j == int'(at_reg)) : (j == int'(fill_reg))) begin
                wr_entries[j] = new_entry;
            end else begin
                wr_entries[j] = row_reg[j];
            end
        end
    end

    assign result = {M_PAD_W'(0), rd_entry_reg.mark, rd_entry_reg.distance, rd_entry_reg.id,
                     rd_valid_reg, upd};

    // state machine
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (clr_addr_reg == AW'(POINTS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                state_next = search_go ? ST_SEARCH : ST_DONE;
            end
            ST_SEARCH: begin
                if (tree_out_valid) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        s_tready  = 1'b0;
        ram_re    = 1'b0;
        ram_we    = 1'b0;
        out_load  = 1'b0;
        ram_waddr = addr_reg;
        ram_wdata = {wr_fill, wr_entries};
        unique case (state_reg)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_addr_reg;
                ram_wdata = '0;
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                ram_re   = s_tvalid;
            end
            ST_LOAD, ST_SEARCH: begin
            end
            ST_DONE: begin
                out_load = out_free;
                ram_we   = out_free && upd;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            func_reg     <= s_tuser;
            point_ok_reg <= in_point_ok;
            addr_reg     <= in_addr;
            cand_reg     <= s_tdata[S_CAND_LSB +: ID_W];
            dist_reg     <= s_tdata[S_DIST_LSB +: DIST_W];
            mark_reg     <= s_tdata[S_MARK_BIT];
            slot_reg     <= s_tdata[S_SLOT_LSB +: SLOT_W];
        end
        if (state_reg == ST_LOAD) begin
            row_reg      <= rd_entries;
            fill_reg     <= rd_fill;
            full_reg     <= full_now;
            dup_reg      <= dup_now;
            rd_valid_reg <= rd_valid_now && (func_reg == FUNC_READ);
            rd_entry_reg <= (rd_valid_now && (func_reg == FUNC_READ)) ? rd_entry_now : '0;
        end
        if (state_reg == ST_SEARCH && tree_out_valid) begin
            far_reg <= tree_out_dist;
            at_reg  <= tree_out_idx;
        end
        if (out_load) begin
            m_tdata_reg <= result;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_accept_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == ST_LOAD))
        else $error("accepted transaction did not start a row read");

    a_write_only_on_update: assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_we && state_reg != ST_CLEAR) |-> (out_load && upd && func_reg == FUNC_UPDATE))
        else $error("row written without an update result");

    a_tree_only_in_search: assert property (@(posedge aclk) disable iff (!aresetn)
        tree_out_valid |-> (state_reg == ST_SEARCH))
        else $error("maximum tree result outside of search");

    a_no_ready_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LOAD || state_reg == ST_SEARCH || state_reg == ST_DONE)
        |-> !s_tready)
        else $error("input ready while a transaction is in flight");

    a_fill_within_k: assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_we && state_reg == ST_DONE && !full_reg) |-> (wr_fill <= k_reg))
        else $error("fill count grew past neighbors in use");

endmodule
